/* hdl/mse_pkg.sv */
// Shared widths, operation codes and MIPS encoding fields for the
// execute/encode block. No dependencies.
package mse_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned OP_W      = 4;
  localparam int unsigned FIELD6_W  = 6;
  localparam int unsigned SHAMT_W   = 5;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IMM_W-1:0]  imm_t;
  typedef logic [FIELD6_W-1:0] field6_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 4'd0,
    OP_ADDU  = 4'd1,
    OP_SUB   = 4'd2,
    OP_SUBU  = 4'd3,
    OP_AND   = 4'd4,
    OP_OR    = 4'd5,
    OP_SLT   = 4'd6,
    OP_MOVE  = 4'd7,
    OP_ADDI  = 4'd8,
    OP_ADDIU = 4'd9,
    OP_ORI   = 4'd10,
    OP_LI    = 4'd11
  } op_t;

  localparam field6_t OPC_SPECIAL = 6'b000000;
  localparam field6_t OPC_ADDI    = 6'b001000;
  localparam field6_t OPC_ADDIU   = 6'b001001;
  localparam field6_t OPC_ORI     = 6'b001101;

  localparam field6_t FN_ADD  = 6'b100000;
  localparam field6_t FN_ADDU = 6'b100001;
  localparam field6_t FN_SUB  = 6'b100010;
  localparam field6_t FN_SUBU = 6'b100011;
  localparam field6_t FN_AND  = 6'b100100;
  localparam field6_t FN_OR   = 6'b100101;
  localparam field6_t FN_SLT  = 6'b101010;

  localparam logic [SHAMT_W-1:0] SHAMT_ZERO = '0;

  function automatic word_t enc_r(idx_t rs, idx_t rt, idx_t rd, field6_t funct);
    return {OPC_SPECIAL, rs, rt, rd, SHAMT_ZERO, funct};
  endfunction

  function automatic word_t enc_i(field6_t opc, idx_t rs, idx_t rt, imm_t imm);
    return {opc, rs, rt, imm};
  endfunction

endpackage

/* hdl/mips_subset_execute_encode.sv */
// Execute/encode stage for a 12-operation MIPS32 integer subset with a
// 32 x 32 register file held in a synchronous memory. Depends on mse_pkg.
//
// Usage:
//   Input channel (in_*): one decoded instruction per transaction, taken
//   when in_valid is high and in_stall is low.
//   Result channel (out_*): one result per instruction: machine encoding,
//   destination index and the value the destination now holds.
//   The register file read completes at the accepting edge; execute and
//   write back load the output register when the stage advances.
//   Throughput: one instruction per cycle while out_stall is low. The
//   register file memory has two read ports and one write port; a write
//   from the execute stage is forwarded to the operands of the instruction
//   read in the same cycle.
//   Stall: while out_stall holds a pending result, the execute stage holds
//   and in_stall rises once it is occupied; no transaction is dropped.
//   Reset: rst_n low empties the pipeline and marks every register as zero
//   through per-entry valid bits; no clearing pass is needed.
//   Unused opcodes give an all-zero result and change no register.
module mips_subset_execute_encode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mse_pkg::OP_W-1:0]      in_opcode,
  input  logic [mse_pkg::IDX_W-1:0]     in_dest_reg,
  input  logic [mse_pkg::IDX_W-1:0]     in_src_a,
  input  logic [mse_pkg::IDX_W-1:0]     in_src_b,
  input  logic [mse_pkg::IMM_W-1:0]     in_immediate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mse_pkg::WORD_W-1:0]    out_machine_word,
  output logic [mse_pkg::IDX_W-1:0]     out_written_index,
  output logic signed [mse_pkg::WORD_W-1:0] out_written_value
);
  import mse_pkg::*;

  word_t rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;

  logic  s1_v_r;
  logic [OP_W-1:0] s1_op_r;
  idx_t  s1_rd_r, s1_rs_r, s1_rt_r;
  imm_t  s1_imm_r;
  word_t rd_a_r, rd_b_r;
  logic  a_vld_r, b_vld_r;

  logic  lw_en_r;
  idx_t  lw_idx_r;
  word_t lw_val_r;

  logic  out_valid_r;
  word_t out_word_r;
  idx_t  out_idx_r;
  word_t out_val_r;

  logic  in_acc, s1_adv;
  word_t op_a, op_b, sext, zext, res_val;
  logic  res_ok;
  word_t out_word_nxt;
  idx_t  out_idx_nxt;
  word_t out_val_nxt;
  logic  wr_en;

  assign s1_adv   = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[s1_rd_r] <= res_val;
    end
    if (in_acc) begin
      rd_a_r <= rf_mem[in_src_a];
      rd_b_r <= rf_mem[in_src_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      s1_v_r  <= 1'b0;
      lw_en_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[s1_rd_r] <= 1'b1;
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (wr_en) begin
        lw_en_r <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_opcode;
      s1_rd_r  <= in_dest_reg;
      s1_rs_r  <= in_src_a;
      s1_rt_r  <= in_src_b;
      s1_imm_r <= in_immediate;
      a_vld_r  <= vld_r[in_src_a];
      b_vld_r  <= vld_r[in_src_b];
    end
    if (wr_en) begin
      lw_idx_r <= s1_rd_r;
      lw_val_r <= res_val;
    end
    if (s1_adv) begin
      out_word_r <= out_word_nxt;
      out_idx_r  <= out_idx_nxt;
      out_val_r  <= out_val_nxt;
    end
  end

  // operand select: zero register, last write back, memory, reset value
  always_comb begin
    if (s1_rs_r == '0) begin
      op_a = '0;
    end else if (lw_en_r && (lw_idx_r == s1_rs_r)) begin
      op_a = lw_val_r;
    end else begin
      op_a = a_vld_r ? rd_a_r : '0;
    end
    if (s1_rt_r == '0) begin
      op_b = '0;
    end else if (lw_en_r && (lw_idx_r == s1_rt_r)) begin
      op_b = lw_val_r;
    end else begin
      op_b = b_vld_r ? rd_b_r : '0;
    end
  end

  assign sext = {{(WORD_W-IMM_W){s1_imm_r[IMM_W-1]}}, s1_imm_r};
  assign zext = {{(WORD_W-IMM_W){1'b0}}, s1_imm_r};

  always_comb begin
    res_ok       = 1'b1;
    res_val      = '0;
    out_word_nxt = '0;
    unique case (op_t'(s1_op_r))
      OP_ADD: begin
        res_val = op_a + op_b;
        out_word_nxt = enc_r(s1_rs_r, s1_rt_r, s1_rd_r, FN_ADD);
      end
      OP_ADDU: begin
        res_val = op_a + op_b;
        out_word_nxt = enc_r(s1_rs_r, s1_rt_r, s1_rd_r, FN_ADDU);
      end
      OP_SUB: begin
        res_val = op_a - op_b;
        out_word_nxt = enc_r(s1_rs_r, s1_rt_r, s1_rd_r, FN_SUB);
      end
      OP_SUBU: begin
        res_val = op_a - op_b;
        out_word_nxt = enc_r(s1_rs_r, s1_rt_r, s1_rd_r, FN_SUBU);
      end
      OP_AND: begin
        res_val = op_a & op_b;
        out_word_nxt = enc_r(s1_rs_r, s1_rt_r, s1_rd_r, FN_AND);
      end
      OP_OR: begin
        res_val = op_a | op_b;
        out_word_nxt = enc_r(s1_rs_r, s1_rt_r, s1_rd_r, FN_OR);
      end
      OP_SLT: begin
        res_val = {{(WORD_W-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
        out_word_nxt = enc_r(s1_rs_r, s1_rt_r, s1_rd_r, FN_SLT);
      end
      OP_MOVE: begin
        res_val = op_a;
        out_word_nxt = enc_r(s1_rs_r, '0, s1_rd_r, FN_ADD);
      end
      OP_ADDI: begin
        res_val = op_a + sext;
        out_word_nxt = enc_i(OPC_ADDI, s1_rs_r, s1_rd_r, s1_imm_r);
      end
      OP_ADDIU: begin
        res_val = op_a + sext;
        out_word_nxt = enc_i(OPC_ADDIU, s1_rs_r, s1_rd_r, s1_imm_r);
      end
      OP_ORI: begin
        res_val = op_a | zext;
        out_word_nxt = enc_i(OPC_ORI, s1_rs_r, s1_rd_r, s1_imm_r);
      end
      OP_LI: begin
        res_val = zext;
        out_word_nxt = enc_i(OPC_ORI, '0, s1_rd_r, s1_imm_r);
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign wr_en       = s1_adv && res_ok && (s1_rd_r != '0);
  assign out_idx_nxt = res_ok ? s1_rd_r : '0;
  assign out_val_nxt = (res_ok && (s1_rd_r != '0)) ? res_val : '0;

  assign out_valid         = out_valid_r;
  assign out_machine_word  = out_word_r;
  assign out_written_index = out_idx_r;
  assign out_written_value = $signed(out_val_r);

`ifndef ASSERT_OFF
  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_rd_r != '0))
    else $error("register zero written");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !s1_adv)
    else $error("execute stage advanced into a blocked output register");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (lw_en_r && (lw_val_r == $past(res_val)) && (lw_idx_r == $past(s1_rd_r))))
    else $error("forwarding register lost the last write back");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_valid_r))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

/* tb/mips_subset_execute_encode_test.sv */
// Self-checking testbench for mips_subset_execute_encode: a directed table, then random
// instructions with random idling on both channels, checked against a shadow register file.
// Depends on mse_pkg and the block's RTL.
module mips_subset_execute_encode_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 4'd12;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 4'd15;
  localparam idx_t ZERO_REG         = '0;
  localparam int   RANDOM_ITEMS     = 1000;
  localparam int   MAX_IDLE         = 10;
  localparam int   LONG_HOLD_CYCLES = 200;
  localparam int   DRAIN_CYCLES     = 8;
  localparam int   TIMEOUT_NS       = 2_000_000;

  typedef struct packed {
    word_t word;
    idx_t  index;
    word_t value;
  } wb_result_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    idx_t            dest;
    idx_t            src_a;
    idx_t            src_b;
    imm_t            imm;
    logic            has_exp;
    wb_result_t      exp;
  } instr_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    in_opcode;
  idx_t               in_dest_reg;
  idx_t               in_src_a;
  idx_t               in_src_b;
  imm_t               in_immediate;
  logic               out_valid;
  logic               out_stall;
  word_t              out_machine_word;
  idx_t               out_written_index;
  logic signed [WORD_W-1:0] out_written_value;

  logic               drv_has_exp;
  wb_result_t         drv_exp;
  logic               no_idle;
  logic               long_hold_req;

  word_t              shadow_regs [REG_COUNT];
  wb_result_t         pending_results [$];
  int                 results_owed = 0;
  int                 mismatches = 0;

  mips_subset_execute_encode u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_dest_reg       (in_dest_reg),
    .in_src_a          (in_src_a),
    .in_src_b          (in_src_b),
    .in_immediate      (in_immediate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_machine_word  (out_machine_word),
    .out_written_index (out_written_index),
    .out_written_value (out_written_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("mips_subset_execute_encode_test: FAIL");
    $finish;
  end

  function automatic wb_result_t execute_instr(logic [OP_W-1:0] opcode, idx_t rd, idx_t rs,
                                               idx_t rt, imm_t imm);
    word_t      a;
    word_t      b;
    word_t      sext;
    word_t      val;
    wb_result_t res;
    logic       known;
    a     = (rs == ZERO_REG) ? '0 : shadow_regs[rs];
    b     = (rt == ZERO_REG) ? '0 : shadow_regs[rt];
    sext  = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
    val   = '0;
    res   = '0;
    known = 1'b1;
    case (opcode)
      OP_ADD: begin
        val = a + b;
        res.word = {OPC_SPECIAL, rs, rt, rd, SHAMT_ZERO, FN_ADD};
      end
      OP_ADDU: begin
        val = a + b;
        res.word = {OPC_SPECIAL, rs, rt, rd, SHAMT_ZERO, FN_ADDU};
      end
      OP_SUB: begin
        val = a - b;
        res.word = {OPC_SPECIAL, rs, rt, rd, SHAMT_ZERO, FN_SUB};
      end
      OP_SUBU: begin
        val = a - b;
        res.word = {OPC_SPECIAL, rs, rt, rd, SHAMT_ZERO, FN_SUBU};
      end
      OP_AND: begin
        val = a & b;
        res.word = {OPC_SPECIAL, rs, rt, rd, SHAMT_ZERO, FN_AND};
      end
      OP_OR: begin
        val = a | b;
        res.word = {OPC_SPECIAL, rs, rt, rd, SHAMT_ZERO, FN_OR};
      end
      OP_SLT: begin
        val = ($signed(a) < $signed(b)) ? word_t'(1) : '0;
        res.word = {OPC_SPECIAL, rs, rt, rd, SHAMT_ZERO, FN_SLT};
      end
      OP_MOVE: begin
        val = a;
        res.word = {OPC_SPECIAL, rs, ZERO_REG, rd, SHAMT_ZERO, FN_ADD};
      end
      OP_ADDI: begin
        val = a + sext;
        res.word = {OPC_ADDI, rs, rd, imm};
      end
      OP_ADDIU: begin
        val = a + sext;
        res.word = {OPC_ADDIU, rs, rd, imm};
      end
      OP_ORI: begin
        val = a | {{(WORD_W-IMM_W){1'b0}}, imm};
        res.word = {OPC_ORI, rs, rd, imm};
      end
      OP_LI: begin
        val = {{(WORD_W-IMM_W){1'b0}}, imm};
        res.word = {OPC_ORI, ZERO_REG, rd, imm};
      end
      default: known = 1'b0;
    endcase
    if (!known) return '0;
    if (rd != ZERO_REG) shadow_regs[rd] = val;
    res.index = rd;
    res.value = (rd == ZERO_REG) ? '0 : val;
    return res;
  endfunction

  function automatic instr_row_t mk_row(logic [OP_W-1:0] opcode, idx_t rd, idx_t rs, idx_t rt,
                                        imm_t imm, logic has_exp, word_t word, idx_t index,
                                        word_t value);
    instr_row_t row;
    row.opcode      = opcode;
    row.dest        = rd;
    row.src_a       = rs;
    row.src_b       = rt;
    row.imm         = imm;
    row.has_exp     = has_exp;
    row.exp.word    = word;
    row.exp.index   = index;
    row.exp.value   = value;
    return row;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_instr(instr_row_t row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      in_opcode    <= $urandom;
      in_dest_reg  <= $urandom;
      in_src_a     <= $urandom;
      in_src_b     <= $urandom;
      in_immediate <= $urandom;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_opcode    <= row.opcode;
    in_dest_reg  <= row.dest;
    in_src_a     <= row.src_a;
    in_src_b     <= row.src_b;
    in_immediate <= row.imm;
    drv_has_exp  <= row.has_exp;
    drv_exp      <= row.exp;
    do @(posedge clk); while (in_stall);
  endtask

  // accepted instructions feed the predictor; accepted results are checked in order
  always @(posedge clk) begin : scoreboard
    wb_result_t pred;
    wb_result_t want;
    if (rst_n && in_valid && !in_stall) begin
      pred = execute_instr(in_opcode, in_dest_reg, in_src_a, in_src_b, in_immediate);
      pending_results.push_back(drv_has_exp ? drv_exp : pred);
      results_owed++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_machine_word, '0);
      end else begin
        want = pending_results.pop_front();
        results_owed--;
        if (out_machine_word !== want.word)
          report_mismatch("machine_word", out_machine_word, want.word);
        if (out_written_index !== want.index)
          report_mismatch("written_index", word_t'(out_written_index), word_t'(want.index));
        if (out_written_value !== want.value)
          report_mismatch("written_value", out_written_value, want.value);
      end
    end
  end

  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  initial begin : stimulus
    instr_row_t directed_q [$];
    instr_row_t row;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = '0;
    in_dest_reg   = '0;
    in_src_a      = '0;
    in_src_b      = '0;
    in_immediate  = '0;
    drv_has_exp   = 1'b0;
    drv_exp       = '0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;

    // typed rows: state after reset, immediate extremes, register zero, unused opcodes
    directed_q.push_back(mk_row(OP_ADD,   1,  0,  0, 16'h0000, 1'b1, 32'h0000_0820, 1, 32'h0));
    directed_q.push_back(mk_row(OP_LI,    1, 31, 31, 16'hFFFF, 1'b1, 32'h3401_FFFF, 1,
                                32'h0000_FFFF));
    directed_q.push_back(mk_row(OP_ADDI,  2,  0,  7, 16'h8000, 1'b1, 32'h2002_8000, 2,
                                32'hFFFF_8000));
    directed_q.push_back(mk_row(OP_ADDIU, 3,  0,  0, 16'h7FFF, 1'b1, 32'h2403_7FFF, 3,
                                32'h0000_7FFF));
    directed_q.push_back(mk_row(OP_LI,    0,  0,  0, 16'h1234, 1'b1, 32'h3400_1234, 0, 32'h0));
    directed_q.push_back(mk_row(OP_RSVD_FIRST, 31, 31, 31, 16'hFFFF, 1'b1, 32'h0, 0, 32'h0));
    directed_q.push_back(mk_row(OP_RSVD_LAST,  31, 31, 31, 16'hFFFF, 1'b1, 32'h0, 0, 32'h0));
    directed_q.push_back(mk_row(OP_ADDI,  6,  0,  0, 16'hFFFF, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_ADD,   9,  6,  6, 16'hFFFF, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_ADDU, 31, 31,  6, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_SUB,   8,  0,  6, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_SUBU, 14,  2,  3, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_AND,  12,  6,  1, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_OR,   13,  2,  1, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_SLT,  10,  2,  3, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_SLT,  11,  3,  2, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_SLT,  15,  6,  6, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_MOVE, 16,  2, 31, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_MOVE,  0,  6,  5, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_ORI,  17,  2,  9, 16'hFFFF, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_ADDIU, 31, 31,  0, 16'h8000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_ADD,   0,  6,  6, 16'hFFFF, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_OR,   19,  0,  6, 16'h0000, 1'b0, '0, '0, '0));
    directed_q.push_back(mk_row(OP_ADD,  18, 31, 31, 16'h0000, 1'b0, '0, '0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) send_instr(directed_q[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n % 250) >= 200;
      if (n == 300) long_hold_req = 1'b1;
      if (n == 600) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_owed == 0);
      end
      if ($urandom_range(0, 19) == 0)
        row.opcode = $urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST);
      else
        row.opcode = $urandom_range(OP_ADD, OP_LI);
      row.dest    = $urandom;
      row.src_a   = $urandom;
      row.src_b   = $urandom;
      row.imm     = $urandom;
      row.has_exp = 1'b0;
      row.exp     = '0;
      send_instr(row);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("mips_subset_execute_encode_test: PASS");
    else
      $display("mips_subset_execute_encode_test: FAIL");
    $finish;
  end

endmodule

/* sim.f */
hdl/mse_pkg.sv
hdl/mips_subset_execute_encode.sv
tb/mips_subset_execute_encode_test.sv
